FILE: design/twte_pkg.sv
// ----------------------------------------------------------------------------
// twte_pkg - shared types and codes of the timing wheel timeout engine
// Opcode and result kind codes, and the packing of the stream payloads.
// ----------------------------------------------------------------------------
package twte_pkg;

    typedef logic [1:0] opcode_t;
    typedef logic [1:0] kind_t;

    // request opcodes
    localparam opcode_t OP_ARM    = 2'd0;
    localparam opcode_t OP_CANCEL = 2'd1;
    localparam opcode_t OP_TICK   = 2'd2;
    localparam opcode_t OP_UNUSED = 2'd3;

    // result kinds
    localparam kind_t KIND_OK      = 2'd0;
    localparam kind_t KIND_REJECT  = 2'd1;
    localparam kind_t KIND_EXPIRED = 2'd2;
    localparam kind_t KIND_NONE    = 2'd3;

    // payload field widths and packing
    localparam int ID_W      = 6;
    localparam int DELAY_W   = 4;
    localparam int IN_DATA_W = 16;
    localparam int OUT_DATA_W = 8;

    // base expiry distance of an arm request, in slots
    localparam int BASE_DELAY = 2;

    // slot pointer value after reset and after wrap
    localparam int SLOT_PTR_INIT = 0;

endpackage

FILE: design/timing_wheel_timeout_engine_unit.sv
// ----------------------------------------------------------------------------
// timing_wheel_timeout_engine_unit - hashed timing wheel timeout engine
// Arms, cancels and expires timeout ids on a wheel of SLOTS slots, with one
// flag word per id held in a memory with one read port and one write port.
// ----------------------------------------------------------------------------
// An arm passes ST_ARM_WR and ST_RESP before its result is loaded; cancel and
// rejects pass ST_RESP alone. A tick scans every id through the one read port,
// in ST_SCN_RD then ST_SCN_CK per id; each expiry waits for the result register.
// One request is in work at a time; s_tready is high only between requests.
// Reset (rst_n low, asynchronous) clears the pointer, all flags via per-id
// valid bits, the sequencer and the output register; no clearing pass.
module timing_wheel_timeout_engine_unit #(
    parameter int SLOTS   = 4,
    parameter int NUM_IDS = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [twte_pkg::IN_DATA_W-1:0]   s_tdata,   // timer_id[5:0], delay_slots[9:6], zeros
    input  twte_pkg::opcode_t                s_tuser,   // opcode[1:0]
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [twte_pkg::OUT_DATA_W-1:0]  m_tdata,   // expired_id[5:0], zeros
    output twte_pkg::kind_t                  m_tuser,   // kind[1:0]
    output logic                             m_tlast
);
    import twte_pkg::*;

    localparam int PW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int IW = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
    localparam int SW = ((PW > DELAY_W) ? PW : DELAY_W) + 1;

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ARM_WR = 3'd1;
    localparam logic [2:0] ST_RESP   = 3'd2;
    localparam logic [2:0] ST_SCN_RD = 3'd3;
    localparam logic [2:0] ST_SCN_CK = 3'd4;
    localparam logic [2:0] ST_FLUSH  = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [PW-1:0]      ptr_reg, ptr_next;
    logic [IW-1:0]      cnt_reg, cnt_next;
    logic [IW-1:0]      held_reg, held_next;
    logic               held_vld_reg, held_vld_next;
    logic [SLOTS-1:0]   mask_reg, mask_next;
    logic [ID_W-1:0]    id_reg, id_next;
    kind_t              resp_kind_reg, resp_kind_next;

    // flag memory with per-id valid bits
    logic [SLOTS-1:0]   mem [NUM_IDS];
    logic [NUM_IDS-1:0] vld_reg;
    logic [SLOTS-1:0]   rd_data_reg;
    logic               rd_vld_reg;
    logic [IW-1:0]      mem_raddr;
    logic [IW-1:0]      mem_waddr;
    logic [SLOTS-1:0]   mem_wdata;
    logic               mem_we;
    logic               vld_clr;
    logic [SLOTS-1:0]   flags;

    // output register
    logic               m_tvalid_reg;
    kind_t              m_kind_reg, m_kind_next;
    logic [ID_W-1:0]    m_id_reg, m_id_next;
    logic               m_last_reg, m_last_next;
    logic               out_load;
    logic               out_free;

    // request decode
    opcode_t            in_op;
    logic [ID_W-1:0]    in_id;
    logic [DELAY_W-1:0] in_delay;
    logic               in_fire;
    logic               id_bad;
    logic               delay_bad;
    logic [SW-1:0]      slot_sum;
    logic [SW-1:0]      slot_idx;
    logic [PW-1:0]      ptr_inc;
    logic               scan_end;
    logic               hit;

    assign in_op    = s_tuser;
    assign in_id    = s_tdata[ID_W-1:0];
    assign in_delay = s_tdata[ID_W +: DELAY_W];
    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign id_bad    = ({1'b0, in_id} >= (ID_W + 1)'(NUM_IDS));
    assign delay_bad = (SW'(in_delay) >= SW'(SLOTS - BASE_DELAY));

    // target slot, one compare and subtract since the sum stays below 2*SLOTS
    assign slot_sum = SW'(ptr_reg) + SW'(in_delay) + SW'(BASE_DELAY);
    assign slot_idx = (slot_sum >= SW'(SLOTS)) ? (slot_sum - SW'(SLOTS)) : slot_sum;

    assign ptr_inc  = (ptr_reg == PW'(SLOTS - 1)) ? PW'(SLOT_PTR_INIT) : (ptr_reg + PW'(1));
    assign scan_end = (cnt_reg == IW'(NUM_IDS - 1));
    assign flags    = rd_vld_reg ? rd_data_reg : '0;
    assign hit      = |(flags & mask_reg);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        cnt_next       = cnt_reg;
        held_next      = held_reg;
        held_vld_next  = held_vld_reg;
        mask_next      = mask_reg;
        id_next        = id_reg;
        resp_kind_next = resp_kind_reg;
        m_kind_next    = m_kind_reg;
        m_id_next      = m_id_reg;
        m_last_next    = m_last_reg;
        out_load       = 1'b0;
        mem_raddr      = in_id[IW-1:0];
        mem_waddr      = id_reg[IW-1:0];
        mem_wdata      = flags | mask_reg;
        mem_we         = 1'b0;
        vld_clr        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    id_next = in_id;
                    case (in_op)
                        OP_ARM:
                        begin
                            if (id_bad || delay_bad)
                            begin
                                resp_kind_next = KIND_REJECT;
                                state_next     = ST_RESP;
                            end
                            else
                            begin
                                mask_next  = SLOTS'(1) << slot_idx;
                                state_next = ST_ARM_WR;
                            end
                        end
                        OP_CANCEL:
                        begin
                            if (id_bad)
                            begin
                                resp_kind_next = KIND_REJECT;
                            end
                            else
                            begin
                                resp_kind_next = KIND_OK;
                                vld_clr        = 1'b1;
                            end
                            state_next = ST_RESP;
                        end
                        OP_TICK:
                        begin
                            ptr_next      = ptr_inc;
                            mask_next     = SLOTS'(1) << ptr_inc;
                            cnt_next      = '0;
                            held_vld_next = 1'b0;
                            state_next    = ST_SCN_RD;
                        end
                        default:
                        begin
                            resp_kind_next = KIND_REJECT;
                            state_next     = ST_RESP;
                        end
                    endcase
                end
            end
            ST_ARM_WR:
            begin
                // merge the new slot into the flags read at transfer
                mem_we         = 1'b1;
                resp_kind_next = KIND_OK;
                state_next     = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    out_load    = 1'b1;
                    m_kind_next = resp_kind_reg;
                    m_id_next   = id_reg;
                    m_last_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_SCN_RD:
            begin
                mem_raddr  = cnt_reg;
                state_next = ST_SCN_CK;
            end
            ST_SCN_CK:
            begin
                mem_raddr = cnt_reg;
                mem_waddr = cnt_reg;
                mem_wdata = flags & ~mask_reg;
                if (!hit || !held_vld_reg || out_free)
                begin
                    if (hit)
                    begin
                        // clear the expired flag, release the previous expiry
                        mem_we        = 1'b1;
                        held_next     = cnt_reg;
                        held_vld_next = 1'b1;
                        if (held_vld_reg)
                        begin
                            out_load    = 1'b1;
                            m_kind_next = KIND_EXPIRED;
                            m_id_next   = ID_W'(held_reg);
                            m_last_next = 1'b0;
                        end
                    end
                    if (scan_end)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + IW'(1);
                        state_next = ST_SCN_RD;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_load    = 1'b1;
                    m_kind_next = held_vld_reg ? KIND_EXPIRED : KIND_NONE;
                    m_id_next   = held_vld_reg ? ID_W'(held_reg) : '0;
                    m_last_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            ptr_reg      <= PW'(SLOT_PTR_INIT);
            cnt_reg      <= '0;
            held_vld_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ptr_reg      <= ptr_next;
            cnt_reg      <= cnt_next;
            held_vld_reg <= held_vld_next;
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        held_reg      <= held_next;
        mask_reg      <= mask_next;
        id_reg        <= id_next;
        resp_kind_reg <= resp_kind_next;
        m_kind_reg    <= m_kind_next;
        m_id_reg      <= m_id_next;
        m_last_reg    <= m_last_next;
    end

    // flag memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    // valid bits: an id never written since reset reads as no flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                vld_reg[mem_waddr] <= 1'b1;
            end
            else if (vld_clr)
            begin
                vld_reg[mem_raddr] <= 1'b0;
            end
            rd_vld_reg <= vld_reg[mem_raddr] && !vld_clr;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = {{(OUT_DATA_W - ID_W){1'b0}}, m_id_reg};
    assign m_tlast  = m_last_reg;

endmodule

FILE: dv/timing_wheel_timeout_engine_unit_checker.sv
// ----------------------------------------------------------------------------
// timing_wheel_timeout_engine_unit_checker - result checker of the wheel
// Watches both streams of the timeout engine, keeps its own copy of the wheel
// to work out the results of every request and compares each result transfer
// against the oldest outstanding result. Reports mismatches and how many
// results are still awaited.
// ----------------------------------------------------------------------------
module timing_wheel_timeout_engine_unit_checker #(
    parameter int SLOTS   = 4,
    parameter int NUM_IDS = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [twte_pkg::IN_DATA_W-1:0]   s_tdata,    // timer_id[5:0], delay_slots[9:6], zeros
    input  twte_pkg::opcode_t                s_tuser,    // opcode[1:0]
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [twte_pkg::OUT_DATA_W-1:0]  m_tdata,    // expired_id[5:0], zeros
    input  twte_pkg::kind_t                  m_tuser,    // kind[1:0]
    input  logic                             m_tlast,
    output int                               mismatches,
    output int                               outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    import twte_pkg::*;

    typedef struct packed {
        kind_t             kind;
        logic [ID_W-1:0]   id;
        logic              last;
    } wheel_result_t;

    // wheel copy: one flag per slot for each id, and the current slot
    logic [SLOTS-1:0]  armed_slots [NUM_IDS];
    int                wheel_pos;
    wheel_result_t     due_results [$];
    int                error_total;

    function automatic void push_result(kind_t kind, logic [ID_W-1:0] id, logic last);
        wheel_result_t r;
        r.kind = kind;
        r.id   = id;
        r.last = last;
        due_results.push_back(r);
    endfunction

    // Update the wheel copy for one request and queue the results it causes
    function automatic void apply_request(opcode_t op, logic [ID_W-1:0] id,
                                          logic [DELAY_W-1:0] delay);
        logic [NUM_IDS-1:0] hits;
        int                 hit_count;
        int                 emitted;
        int                 slot;
        hits      = '0;
        hit_count = 0;
        emitted   = 0;
        case (op)
            OP_ARM:
            begin
                if (int'(delay) >= SLOTS - 2 || int'(id) >= NUM_IDS)
                begin
                    push_result(KIND_REJECT, id, 1'b1);
                end
                else
                begin
                    slot = (wheel_pos + int'(delay) + BASE_DELAY) % SLOTS;
                    armed_slots[id][slot] = 1'b1;
                    push_result(KIND_OK, id, 1'b1);
                end
            end
            OP_CANCEL:
            begin
                if (int'(id) >= NUM_IDS)
                begin
                    push_result(KIND_REJECT, id, 1'b1);
                end
                else
                begin
                    armed_slots[id] = '0;
                    push_result(KIND_OK, id, 1'b1);
                end
            end
            OP_TICK:
            begin
                // advance with wrap, then collect and clear the new slot
                wheel_pos = (wheel_pos + 1 >= SLOTS) ? SLOT_PTR_INIT : wheel_pos + 1;
                for (int i = 0; i < NUM_IDS; i++)
                begin
                    if (armed_slots[i][wheel_pos])
                    begin
                        hits[i] = 1'b1;
                        hit_count++;
                        armed_slots[i][wheel_pos] = 1'b0;
                    end
                end
                if (hit_count == 0)
                begin
                    push_result(KIND_NONE, '0, 1'b1);
                end
                for (int i = 0; i < NUM_IDS; i++)
                begin
                    if (hits[i])
                    begin
                        emitted++;
                        push_result(KIND_EXPIRED, ID_W'(i), emitted == hit_count);
                    end
                end
            end
            default:
            begin
                push_result(KIND_REJECT, id, 1'b1);
            end
        endcase
    endfunction

    // Check each result transfer first, then predict from a request transfer
    always @(posedge clk or negedge rst_n)
    begin
        wheel_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_IDS; i++)
            begin
                armed_slots[i] = '0;
            end
            wheel_pos   = SLOT_PTR_INIT;
            error_total = 0;
            due_results.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (due_results.size() == 0)
                begin
                    $error("unexpected result: kind %0d, expired_id %0d, last %0d",
                           m_tuser, m_tdata[ID_W-1:0], m_tlast);
                    error_total++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (m_tuser !== want.kind)
                    begin
                        $error("kind: expected %0d, actual %0d", want.kind, m_tuser);
                        error_total++;
                    end
                    if (m_tdata[ID_W-1:0] !== want.id)
                    begin
                        $error("expired_id: expected %0d, actual %0d",
                               want.id, m_tdata[ID_W-1:0]);
                        error_total++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last: expected %0d, actual %0d", want.last, m_tlast);
                        error_total++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                apply_request(s_tuser, s_tdata[ID_W-1:0], s_tdata[ID_W +: DELAY_W]);
            end
            mismatches  <= error_total;
            outstanding <= due_results.size();
        end
    end

endmodule

FILE: dv/timing_wheel_timeout_engine_unit_test.sv
// ----------------------------------------------------------------------------
// timing_wheel_timeout_engine_unit_test - testbench of the timeout engine
// Drives arm, cancel, tick and unused requests into the engine, first a short
// directed sequence over the corner cases, then random traffic with random
// gaps and result stalls, including one long stall that backs up the input.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module timing_wheel_timeout_engine_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import twte_pkg::*;

    localparam int SLOTS          = 4;
    localparam int NUM_IDS        = 64;
    localparam int RANDOM_REQUESTS = 280;
    localparam int HOLD_CYCLES    = 300;
    localparam int IDLE_LIMIT     = 3000;
    localparam int SETTLE_CYCLES  = 10;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata;
    opcode_t                s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;
    kind_t                  m_tuser;
    logic                   m_tlast;

    int mismatches;
    int outstanding;
    int result_transfers;
    int idle_cycles;

    timing_wheel_timeout_engine_unit #(
        .SLOTS   (SLOTS),
        .NUM_IDS (NUM_IDS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    timing_wheel_timeout_engine_unit_checker #(
        .SLOTS   (SLOTS),
        .NUM_IDS (NUM_IDS)
    ) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // count result transfers so the long stall can start once traffic flows
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_transfers <= 0;
        end
        else if (m_tvalid && m_tready)
        begin
            result_transfers <= result_transfers + 1;
        end
    end

    // Idle length: mostly short, now and then long
    function automatic int pick_gap(int shortest);
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return shortest;
        end
        if (r < 90)
        begin
            return $urandom_range(shortest, shortest + 3);
        end
        return $urandom_range(15, 50);
    endfunction

    // Offer one request and hold it until the transfer, then maybe idle
    task automatic send_request(opcode_t op, logic [ID_W-1:0] id, logic [DELAY_W-1:0] delay);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(IN_DATA_W - ID_W - DELAY_W){1'b0}}, delay, id};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        gap = pick_gap(0);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Result side: bursts of ready, random stalls, one long hold-off
    initial
    begin
        bit held;
        int pick;
        held = 1'b0;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            pick = $urandom_range(0, 9);
            if (!held && result_transfers >= 30)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (pick < 2)
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(20, 80)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                m_tready <= 1'b0;
                repeat (pick_gap(1)) @(posedge clk);
            end
        end
    end

    // watchdog: end the run when no transfer happens for too long
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("FAIL timing_wheel_timeout_engine_unit");
        $finish;
    end

    // stimulus and verdict
    initial
    begin
        int r;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_ARM;
        rst_n    <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty tick, arms at both ends of the id range and delay range
        send_request(OP_TICK,   6'd33, 4'd9);
        send_request(OP_ARM,    6'd0,  4'd0);
        send_request(OP_ARM,    6'd63, 4'd1);
        // re-arm an armed id into a second slot
        send_request(OP_ARM,    6'd63, 4'd0);
        // delays too long for the wheel
        send_request(OP_ARM,    6'd21, 4'd2);
        send_request(OP_ARM,    6'd42, 4'd15);
        send_request(OP_ARM,    6'd21, 4'd3);
        // cancel of an idle id, unused opcode
        send_request(OP_CANCEL, 6'd42, 4'd6);
        send_request(OP_UNUSED, 6'd42, 4'd5);
        send_request(OP_ARM,    6'd42, 4'd0);
        send_request(OP_ARM,    6'd5,  4'd1);
        // cancel of an armed id
        send_request(OP_CANCEL, 6'd5,  4'd0);
        send_request(OP_UNUSED, 6'd21, 4'd10);
        // walk the whole wheel: empty, several expiries, one, empty
        send_request(OP_TICK,   6'd0,  4'd0);
        send_request(OP_TICK,   6'd63, 4'd15);
        send_request(OP_TICK,   6'd21, 4'd0);
        send_request(OP_TICK,   6'd42, 4'd6);

        // random traffic: mostly valid arms, cancels and ticks
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    send_request(OP_ARM, ID_W'($urandom), DELAY_W'($urandom));
                end
                else
                begin
                    send_request(OP_ARM, ID_W'($urandom),
                                 DELAY_W'($urandom_range(0, SLOTS - 3)));
                end
            end
            else if (r < 65)
            begin
                send_request(OP_CANCEL, ID_W'($urandom), DELAY_W'($urandom));
            end
            else if (r < 88)
            begin
                send_request(OP_TICK, ID_W'($urandom), DELAY_W'($urandom));
            end
            else
            begin
                send_request(opcode_t'($urandom), ID_W'($urandom), DELAY_W'($urandom));
            end
        end
        s_tvalid <= 1'b0;

        // drain the remaining results, then let the block settle
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("PASS timing_wheel_timeout_engine_unit");
        end
        else
        begin
            $display("FAIL timing_wheel_timeout_engine_unit");
        end
        $finish;
    end

endmodule
